// ===== rtl/core/mrf_pkg.sv =====
package mrf_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0]  SLAVE_RESET   = 8'h02;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  FUNC_READ     = 8'h03;
    localparam logic [7:0]  FUNC_WRITE    = 8'h06;
    localparam logic [15:0] READ_QUANTITY = 16'h0001;
    localparam logic [15:0] READING_LIMIT = 16'd1000;
    localparam logic [2:0]  RX_COUNT_MAX  = 3'd7;
    localparam logic [2:0]  RX_IDX_HIGH   = 3'd3;
    localparam logic [2:0]  RX_IDX_LOW    = 3'd4;
    localparam logic [2:0]  TX_IDX_LAST   = 3'd7;
    localparam logic [2:0]  TX_IDX_DATA_LO = 3'd5;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_RESP  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READING = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] addr;
        logic [15:0] data;
        logic        over_limit;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_port_t;

endpackage

// ===== rtl/core/modbus_rtu_register_framer.sv =====
// Channel   Direction  Handshake               Payload
// request   in         push / full             kind, register_address, write_value,
//                                              rx_byte, rx_frame_start
// result    out        empty / pop             out_kind, tx_byte, frame_last, reading
// config    in         cfg_valid / cfg_ready   cfg_data (slave address)
//
// A read or write request produces eight result bytes, one per cycle while pop is high.
// The fifth byte of a response frame (index four) yields one reading.
// An accepted request is first written into the queue; its result is then registered on the output.
// Reset clears the queue, the receive counters and the output valid flag; slave address returns to 2.
// A stalled result stays on the ports while requests keep filling the queue until full.
module modbus_rtu_register_framer
    import mrf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [15:0] register_address,
    input  logic [15:0] write_value,
    input  logic [7:0]  rx_byte,
    input  logic        rx_frame_start,
    output logic        empty,
    input  logic        pop,
    output logic        out_kind,
    output logic [7:0]  tx_byte,
    output logic        frame_last,
    output logic [16:0] reading,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    q_port_t enq;
    q_port_t head;
    logic    deq;
    logic    q_full;

    assign full      = q_full;
    assign cfg_ready = 1'b1;

    mrf_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .q_full           (q_full),
        .kind             (kind),
        .register_address (register_address),
        .write_value      (write_value),
        .rx_byte          (rx_byte),
        .rx_frame_start   (rx_frame_start),
        .enq              (enq)
    );

    mrf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .enq   (enq),
        .deq   (deq),
        .full  (q_full),
        .head  (head)
    );

    mrf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .head       (head),
        .deq        (deq),
        .pop        (pop),
        .empty      (empty),
        .out_kind   (out_kind),
        .tx_byte    (tx_byte),
        .frame_last (frame_last),
        .reading    (reading)
    );

endmodule

// ===== rtl/core/mrf_front.sv =====
module mrf_front
    import mrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        q_full,
    input  logic [1:0]  kind,
    input  logic [15:0] register_address,
    input  logic [15:0] write_value,
    input  logic [7:0]  rx_byte,
    input  logic        rx_frame_start,
    output q_port_t     enq
);

    logic [2:0] rx_count_reg;
    logic [2:0] rx_count_next;
    logic [7:0] rx_high_byte_reg;
    logic [7:0] rx_high_byte_next;
    logic       accept;
    logic [2:0] idx;
    logic [15:0] value;

    assign accept = push && !q_full;
    assign idx    = rx_frame_start ? 3'd0 : rx_count_reg;
    assign value  = {rx_high_byte_reg, rx_byte};

    always_comb
    begin
        rx_count_next     = rx_count_reg;
        rx_high_byte_next = rx_high_byte_reg;
        enq.valid            = 1'b0;
        enq.entry.cmd        = CMD_READ;
        enq.entry.addr       = register_address;
        enq.entry.data       = write_value;
        enq.entry.over_limit = 1'b0;
        if (accept)
        begin
            unique case (kind_t'(kind))
                KIND_READ:
                begin
                    enq.valid      = 1'b1;
                    enq.entry.cmd  = CMD_READ;
                    enq.entry.data = READ_QUANTITY;
                end
                KIND_WRITE:
                begin
                    enq.valid     = 1'b1;
                    enq.entry.cmd = CMD_WRITE;
                end
                KIND_RESP:
                begin
                    if (idx == RX_IDX_HIGH)
                    begin
                        rx_high_byte_next = rx_byte;
                    end
                    else if (idx == RX_IDX_LOW)
                    begin
                        enq.valid            = 1'b1;
                        enq.entry.cmd        = CMD_READING;
                        enq.entry.data       = value;
                        enq.entry.over_limit = value > READING_LIMIT;
                    end
                    rx_count_next = (idx < RX_COUNT_MAX) ? idx + 3'd1 : RX_COUNT_MAX;
                end
                default:
                begin
                    enq.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg     <= 3'd0;
            rx_high_byte_reg <= 8'h00;
        end
        else
        begin
            rx_count_reg     <= rx_count_next;
            rx_high_byte_reg <= rx_high_byte_next;
        end
    end

endmodule

// ===== rtl/core/mrf_queue.sv =====
module mrf_queue
    import mrf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_port_t enq,
    input  logic    deq,
    output logic    full,
    output q_port_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    entry_t           entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_enq;
    logic             do_deq;

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.entry = entries_reg[rd_ptr_reg];
    assign do_enq     = enq.valid && !full;
    assign do_deq     = deq && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_enq)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_deq)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_enq && !do_deq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!do_enq && do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            entries_reg[wr_ptr_reg] <= enq.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("Queue count exceeds its depth.");

    a_no_enq_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !enq.valid)
        else $error("Front issued a request into a full queue.");

endmodule

// ===== rtl/core/mrf_back.sv =====
module mrf_back
    import mrf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_data,
    input  q_port_t      head,
    output logic         deq,
    input  logic         pop,
    output logic         empty,
    output logic         out_kind,
    output logic [7:0]   tx_byte,
    output logic         frame_last,
    output logic [16:0]  reading
);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [7:0]  slave_address_reg;
    logic [2:0]  byte_idx_reg;
    logic [2:0]  byte_idx_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_kind_reg;
    logic [7:0]  tx_byte_reg;
    logic        frame_last_reg;
    logic [16:0] reading_reg;
    logic        slot_free;
    logic        emit;
    logic        is_reading;
    logic [7:0]  cur_byte;

    assign slot_free  = !out_valid_reg || pop;
    assign emit       = head.valid && slot_free;
    assign is_reading = (head.entry.cmd == CMD_READING);

    always_comb
    begin
        case (byte_idx_reg)
            3'd0:    cur_byte = slave_address_reg;
            3'd1:    cur_byte = (head.entry.cmd == CMD_READ) ? FUNC_READ : FUNC_WRITE;
            3'd2:    cur_byte = head.entry.addr[15:8];
            3'd3:    cur_byte = head.entry.addr[7:0];
            3'd4:    cur_byte = head.entry.data[15:8];
            3'd5:    cur_byte = head.entry.data[7:0];
            3'd6:    cur_byte = crc_reg[7:0];
            default: cur_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        byte_idx_next  = byte_idx_reg;
        crc_next       = crc_reg;
        deq            = 1'b0;
        out_valid_next = pop ? 1'b0 : out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (is_reading)
            begin
                deq = 1'b1;
            end
            else
            begin
                byte_idx_next = byte_idx_reg + 3'd1;
                deq           = (byte_idx_reg == TX_IDX_LAST);
                if (byte_idx_reg <= TX_IDX_DATA_LO)
                begin
                    crc_next = crc_byte((byte_idx_reg == 3'd0) ? CRC_INIT : crc_reg, cur_byte);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg   <= is_reading;
            tx_byte_reg    <= is_reading ? 8'h00 : cur_byte;
            frame_last_reg <= !is_reading && (byte_idx_reg == TX_IDX_LAST);
            reading_reg    <= is_reading ? {head.entry.over_limit, head.entry.data} : 17'd0;
        end
        crc_reg <= crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= SLAVE_RESET;
            byte_idx_reg      <= 3'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                slave_address_reg <= cfg_data;
            end
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign tx_byte    = tx_byte_reg;
    assign frame_last = frame_last_reg;
    assign reading    = reading_reg;

    a_frame_held: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_idx_reg != 3'd0) |-> (head.valid && !is_reading))
        else $error("Request left the queue head in the middle of a frame.");

    a_last_dequeues: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !is_reading && byte_idx_reg == TX_IDX_LAST) |=>
            (byte_idx_reg == 3'd0 && frame_last_reg))
        else $error("Final frame byte did not close the frame.");

    a_deq_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> emit)
        else $error("Queue entry released without producing a result.");

endmodule
